// ===== rtl/u5frp_pkg.sv =====
// Package for the field record parser: shared types and coding constants.
// No dependencies; used by the decoder, the record tracker, the top level and the testbench.

package u5frp_pkg;

   // number coding constants
   localparam logic [8:0] U5_BIAS       = 9'd1;
   localparam logic [7:0] U5_LEAD_LIMIT = 8'd191;  // last lead byte that ends a number
   localparam logic [7:0] U5_CONT_LIMIT = 8'd192;  // continuation bytes below this end it
   localparam logic [2:0] U5_LAST_POS   = 3'd4;    // fifth byte always ends a number
   localparam int         U5_SHIFT_STEP = 6;

   // field flag bits that each add one extra number to a record
   localparam int FLAG_EXTRA_A = 0;
   localparam int FLAG_EXTRA_B = 2;
   localparam int FLAG_EXTRA_C = 4;

   // access flag bit for static fields
   localparam int ACCESS_STATIC_BIT = 3;

   // which number of the stream is expected
   typedef enum logic [8:0] {
      PH_COUNT1 = 9'b0_0000_0001,
      PH_COUNT2 = 9'b0_0000_0010,
      PH_NAME   = 9'b0_0000_0100,
      PH_SIG    = 9'b0_0000_1000,
      PH_OFFSET = 9'b0_0001_0000,
      PH_ACCESS = 9'b0_0010_0000,
      PH_FLAGS  = 9'b0_0100_0000,
      PH_EXTRAS = 9'b0_1000_0000,
      PH_IDLE   = 9'b1_0000_0000
   } phase_type;

   // decoded number handed from the byte decoder to the record tracker
   typedef struct packed {
      logic        complete;
      logic [63:0] value;
   } number_type;

   // one parsed field record
   typedef struct packed {
      logic [31:0]        name_index;
      logic [31:0]        signature_index;
      logic signed [31:0] field_offset;
      logic signed [31:0] access_bits;
      logic               static_flag;
      logic               final_record;
   } record_type;

endpackage

// ===== rtl/u5frp_decode.sv =====
// Byte decoder: accumulates one variable-length number from the byte stream.
// Depends on u5frp_pkg.

module u5frp_decode
   import u5frp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] stream_byte,
   input  logic       end_of_stream,
   output number_type number
);

   logic [63:0] acc_ff, acc_in;
   logic [2:0]  pos_ff, pos_in;
   logic [8:0]  biased;
   logic [63:0] term;
   logic        done;

   // byte minus bias, sign extended and placed at its digit position
   always_comb begin
      biased = {1'b0, stream_byte} - U5_BIAS;
      term   = {{55{biased[8]}}, biased} << (U5_SHIFT_STEP * int'(pos_ff));
   end

   // running sum and end-of-number test
   always_comb begin
      if (pos_ff == 3'd0) begin
         if (stream_byte == 8'd0) begin
            acc_in = 64'd0;
         end else begin
            acc_in = {56'd0, biased[7:0]};
         end
         done = (stream_byte <= U5_LEAD_LIMIT);
      end else begin
         acc_in = acc_ff + term;
         done   = (stream_byte < U5_CONT_LIMIT) || (pos_ff >= U5_LAST_POS);
      end
      number.complete = done || end_of_stream;
      number.value    = acc_in;
      pos_in          = number.complete ? 3'd0 : pos_ff + 3'd1;
   end

   // state update per consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 64'd0;
         pos_ff <= 3'd0;
      end else if (step) begin
         acc_ff <= number.complete ? 64'd0 : acc_in;
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== rtl/u5frp_record.sv =====
// Record tracker: header counts, field slots, extra skipping and record emission.
// Depends on u5frp_pkg; fed by u5frp_decode.

module u5frp_record
   import u5frp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       end_of_stream,
   input  number_type number,
   output logic       active,
   output logic       emit,
   output record_type record
);

   phase_type   phase_ff, phase_in;
   logic [63:0] first_ff, first_in;
   logic [63:0] left_ff, left_in;
   logic [31:0] name_ff, name_in;
   logic [31:0] sig_ff, sig_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] access_ff, access_in;
   logic [1:0]  pend_ff, pend_in;
   logic        done_ff, done_in;
   logic [1:0]  extra_cnt;
   logic        last_by_count;

   assign active        = !done_ff && (phase_ff != PH_IDLE);
   assign last_by_count = (left_ff == 64'd1);

   always_comb begin
      extra_cnt = {1'b0, number.value[FLAG_EXTRA_A]} + {1'b0, number.value[FLAG_EXTRA_B]}
                + {1'b0, number.value[FLAG_EXTRA_C]};
   end

   // slot sequencing
   always_comb begin
      phase_in  = phase_ff;
      first_in  = first_ff;
      left_in   = left_ff;
      name_in   = name_ff;
      sig_in    = sig_ff;
      offset_in = offset_ff;
      access_in = access_ff;
      pend_in   = pend_ff;
      done_in   = done_ff;
      emit      = 1'b0;

      if (active && number.complete) begin
         case (phase_ff)
            PH_COUNT1: begin
               first_in = number.value;
               phase_in = PH_COUNT2;
            end
            PH_COUNT2: begin
               left_in  = first_ff + number.value;
               phase_in = (left_in != 64'd0) ? PH_NAME : PH_IDLE;
            end
            PH_NAME: begin
               name_in  = number.value[31:0];
               phase_in = PH_SIG;
            end
            PH_SIG: begin
               sig_in   = number.value[31:0];
               phase_in = PH_OFFSET;
            end
            PH_OFFSET: begin
               offset_in = number.value[31:0];
               phase_in  = PH_ACCESS;
            end
            PH_ACCESS: begin
               access_in = number.value[31:0];
               phase_in  = PH_FLAGS;
            end
            PH_FLAGS: begin
               if (extra_cnt == 2'd0) begin
                  emit = 1'b1;
               end else begin
                  pend_in  = extra_cnt;
                  phase_in = PH_EXTRAS;
               end
            end
            PH_EXTRAS: begin
               pend_in = (pend_ff == 2'd0) ? 2'd0 : pend_ff - 2'd1;
               if (pend_in == 2'd0) begin
                  emit = 1'b1;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      // stream ending inside a record still flushes it
      if (active && end_of_stream && !emit &&
          (phase_in inside {PH_SIG, PH_OFFSET, PH_ACCESS, PH_FLAGS, PH_EXTRAS})) begin
         emit = 1'b1;
      end

      record.name_index      = name_in;
      record.signature_index = sig_in;
      record.field_offset    = offset_in;
      record.access_bits     = access_in;
      record.static_flag     = access_in[ACCESS_STATIC_BIT];
      record.final_record    = last_by_count || end_of_stream;

      // clear the record slots after emission
      if (emit) begin
         left_in   = left_ff - 64'd1;
         phase_in  = last_by_count ? PH_IDLE : PH_NAME;
         name_in   = 32'd0;
         sig_in    = 32'd0;
         offset_in = 32'd0;
         access_in = 32'd0;
         pend_in   = 2'd0;
      end

      if (end_of_stream) begin
         done_in = 1'b1;
      end
   end

   // tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_COUNT1;
         first_ff  <= 64'd0;
         left_ff   <= 64'd0;
         name_ff   <= 32'd0;
         sig_ff    <= 32'd0;
         offset_ff <= 32'd0;
         access_ff <= 32'd0;
         pend_ff   <= 2'd0;
         done_ff   <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         left_ff   <= left_in;
         name_ff   <= name_in;
         sig_ff    <= sig_in;
         offset_ff <= offset_in;
         access_ff <= access_in;
         pend_ff   <= pend_in;
         done_ff   <= done_in;
      end
   end

endmodule

// ===== rtl/unsigned5_field_record_parser.sv =====
// Results: a result is written to the result register once the request byte ending its
// record is in the request register and the result register is free.
// Throughput: one request byte per cycle; the only wait is a held result under rsp_stall.
// Pace is set by the single decode step between the request register and result register.
// Reset: synchronous, active high; clears the valid flags of both registers, the running
// number and all record state, so the parser expects the first header count again.

module unsigned5_field_record_parser
   import u5frp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_stream_byte,
   input  logic               req_end_of_stream,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_name_index,
   output logic [31:0]        rsp_signature_index,
   output logic signed [31:0] rsp_field_offset,
   output logic signed [31:0] rsp_access_bits,
   output logic               rsp_static_flag,
   output logic               rsp_final_record
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;
   logic       rsp_valid_ff;
   record_type rsp_ff;
   logic       out_free;
   logic       advance;
   logic       active;
   logic       emit;
   number_type number;
   record_type record;

   // pipeline flow
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !advance;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_stream_byte;
         in_eos_ff  <= req_end_of_stream;
      end
   end

   u5frp_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .step          (advance && active),
      .stream_byte   (in_byte_ff),
      .end_of_stream (in_eos_ff),
      .number        (number)
   );

   u5frp_record u_record (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .end_of_stream (in_eos_ff),
      .number        (number),
      .active        (active),
      .emit          (emit),
      .record        (record)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ff <= record;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_name_index      = rsp_ff.name_index;
   assign rsp_signature_index = rsp_ff.signature_index;
   assign rsp_field_offset    = rsp_ff.field_offset;
   assign rsp_access_bits     = rsp_ff.access_bits;
   assign rsp_static_flag     = rsp_ff.static_flag;
   assign rsp_final_record    = rsp_ff.final_record;

endmodule

// ===== rtl/u5frp_checker.sv =====
// Port-level checks for the field record parser, bound to the top level.
// Depends only on the ports of unsigned5_field_record_parser.

module u5frp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_access_bits,
   input logic               rsp_static_flag
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // static bit follows the access flags
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_static_flag == rsp_access_bits[3]))
      else $error("static bit does not match access flags");

   // a fresh result comes from an accepted request through the request and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching request");

endmodule

bind unsigned5_field_record_parser u5frp_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_access_bits (rsp_access_bits),
   .rsp_static_flag (rsp_static_flag)
);

// ===== test/field_record_checker.sv =====
// Checker for the field record parser: predicts each record from the request bytes
// and compares it with the result channel. Depends on u5frp_pkg for the record and
// phase types and the coding constants.

module field_record_checker
   import u5frp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_stream_byte,
   input  logic               req_end_of_stream,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [31:0]        rsp_name_index,
   input  logic [31:0]        rsp_signature_index,
   input  logic signed [31:0] rsp_field_offset,
   input  logic signed [31:0] rsp_access_bits,
   input  logic               rsp_static_flag,
   input  logic               rsp_final_record,
   output int                 fail_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // parser state as seen from the byte stream
   phase_type   parse_phase;
   logic [63:0] running_sum;
   logic [2:0]  digit_pos;
   logic [63:0] records_left;
   logic [63:0] first_count;
   logic [31:0] held_name;
   logic [31:0] held_signature;
   logic [31:0] held_offset;
   logic [63:0] held_access;
   logic [1:0]  extras_left;
   logic        stream_ended;

   record_type  expected_records[$];
   record_type  oldest;
   int          mismatches = 0;

   // queue the record under way and start the next one
   task automatic close_record(input logic at_end);
      record_type rec;
      records_left        = records_left - 64'd1;
      rec.name_index      = held_name;
      rec.signature_index = held_signature;
      rec.field_offset    = held_offset;
      rec.access_bits     = held_access[31:0];
      rec.static_flag     = held_access[ACCESS_STATIC_BIT];
      rec.final_record    = (records_left == 64'd0) || at_end;
      expected_records.insert(expected_records.size(), rec);
      held_name      = '0;
      held_signature = '0;
      held_offset    = '0;
      held_access    = '0;
      extras_left    = '0;
      parse_phase    = (records_left != 64'd0) ? PH_NAME : PH_IDLE;
   endtask

   // advance the parser by one request byte
   task automatic parse_stream_byte(input logic [7:0] b, input logic eos);
      logic [63:0] number;
      logic        number_done;
      logic        emitted;
      if (stream_ended)
         return;
      if (parse_phase == PH_IDLE) begin
         if (eos)
            stream_ended = 1'b1;
         return;
      end

      // fold the byte into the number under way
      if (digit_pos == 3'd0) begin
         if (b == 8'd0) begin
            running_sum = '0;
            number_done = 1'b1;
         end else begin
            running_sum = 64'(b) - 64'(U5_BIAS);
            number_done = running_sum < 64'(U5_LEAD_LIMIT);
         end
      end else begin
         running_sum = running_sum
                     + ((64'(b) - 64'(U5_BIAS)) << (U5_SHIFT_STEP * digit_pos));
         number_done = (b < U5_CONT_LIMIT) || (digit_pos >= U5_LAST_POS);
      end
      if (!number_done && !eos) begin
         digit_pos = digit_pos + 3'd1;
         return;
      end

      number      = running_sum;
      running_sum = '0;
      digit_pos   = '0;
      emitted     = 1'b0;

      // hand the finished number to the slot it belongs to
      case (parse_phase)
         PH_COUNT1: begin
            first_count = number;
            parse_phase = PH_COUNT2;
         end
         PH_COUNT2: begin
            records_left = first_count + number;
            parse_phase  = (records_left != 64'd0) ? PH_NAME : PH_IDLE;
         end
         PH_NAME: begin
            held_name   = number[31:0];
            parse_phase = PH_SIG;
         end
         PH_SIG: begin
            held_signature = number[31:0];
            parse_phase    = PH_OFFSET;
         end
         PH_OFFSET: begin
            held_offset = number[31:0];
            parse_phase = PH_ACCESS;
         end
         PH_ACCESS: begin
            held_access = number;
            parse_phase = PH_FLAGS;
         end
         PH_FLAGS: begin
            extras_left = 2'(number[FLAG_EXTRA_A]) + 2'(number[FLAG_EXTRA_B])
                        + 2'(number[FLAG_EXTRA_C]);
            if (extras_left == 2'd0) begin
               close_record(eos);
               emitted = 1'b1;
            end else begin
               parse_phase = PH_EXTRAS;
            end
         end
         PH_EXTRAS: begin
            if (extras_left != 2'd0)
               extras_left = extras_left - 2'd1;
            if (extras_left == 2'd0) begin
               close_record(eos);
               emitted = 1'b1;
            end
         end
         default: ;
      endcase

      // end of stream flushes a record that has started
      if (eos) begin
         if (!emitted && parse_phase inside {PH_SIG, PH_OFFSET, PH_ACCESS, PH_FLAGS, PH_EXTRAS})
            close_record(1'b1);
         stream_ended = 1'b1;
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatches++;
      end
   endtask

   // compare results first, then predict from the request of this edge
   always @(posedge clock) begin
      if (reset) begin
         parse_phase    = PH_COUNT1;
         running_sum    = '0;
         digit_pos      = '0;
         records_left   = '0;
         first_count    = '0;
         held_name      = '0;
         held_signature = '0;
         held_offset    = '0;
         held_access    = '0;
         extras_left    = '0;
         stream_ended   = 1'b0;
         expected_records.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_records.size() == 0) begin
               $error("unexpected record: name_index %0h", rsp_name_index);
               mismatches++;
            end else begin
               oldest = expected_records.pop_front();
               check_field("name_index", oldest.name_index, rsp_name_index);
               check_field("signature_index", oldest.signature_index, rsp_signature_index);
               check_field("field_offset", oldest.field_offset, rsp_field_offset);
               check_field("access_bits", oldest.access_bits, rsp_access_bits);
               check_field("static_flag", 32'(oldest.static_flag), 32'(rsp_static_flag));
               check_field("final_record", 32'(oldest.final_record), 32'(rsp_final_record));
            end
         end
         if (req_valid && !req_stall)
            parse_stream_byte(req_stream_byte, req_end_of_stream);
      end
      fail_count    <= mismatches;
      pending_count <= expected_records.size();
   end

endmodule

// ===== test/testbench.sv =====
// Top of the field record parser testbench: builds one coded field stream, sends it
// in bursts under random result stalls and gives the verdict. Depends on u5frp_pkg,
// unsigned5_field_record_parser and field_record_checker.

module testbench
   import u5frp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          ITEM_TARGET  = 900;
   localparam int          IDLE_LIMIT   = 1000;
   localparam int          DRAIN_CYCLES = 8;
   localparam logic [63:0] DIGIT_RADIX  = 64'd1 << U5_SHIFT_STEP;
   localparam logic [63:0] CORNER_VALUES [9] = '{
      64'd0, 64'd1, 64'd8, 64'd190, 64'd191,
      64'h7FFF_FFFF, 64'h8000_0000, 64'hFFFF_FFF7, 64'hFFFF_FFFF
   };

   typedef enum {END_BY_COUNT, END_IN_RECORD} stream_end_type;
   typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_BEAT} stall_style_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_stream_byte = 8'd0;
   logic               req_end_of_stream = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [31:0]        rsp_name_index;
   logic [31:0]        rsp_signature_index;
   logic signed [31:0] rsp_field_offset;
   logic signed [31:0] rsp_access_bits;
   logic               rsp_static_flag;
   logic               rsp_final_record;
   int                 fail_count;
   int                 pending_count;

   logic [7:0]      field_bytes[$];
   logic [7:0]      record_bytes[$];
   stream_end_type  stream_end;
   stall_style_type stall_style = STALL_NONE;
   int              stall_run = 0;
   int              idle_cycles = 0;
   int              record_total;
   int              directed_len;
   int              pause_at;
   int              eos_at;
   int              tail_start;
   int              burst_left;
   int              head_count;
   int              i;

   always #5 clock = ~clock;

   unsigned5_field_record_parser u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_stream_byte     (req_stream_byte),
      .req_end_of_stream   (req_end_of_stream),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_name_index      (rsp_name_index),
      .rsp_signature_index (rsp_signature_index),
      .rsp_field_offset    (rsp_field_offset),
      .rsp_access_bits     (rsp_access_bits),
      .rsp_static_flag     (rsp_static_flag),
      .rsp_final_record    (rsp_final_record)
   );

   field_record_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_stream_byte     (req_stream_byte),
      .req_end_of_stream   (req_end_of_stream),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_name_index      (rsp_name_index),
      .rsp_signature_index (rsp_signature_index),
      .rsp_field_offset    (rsp_field_offset),
      .rsp_access_bits     (rsp_access_bits),
      .rsp_static_flag     (rsp_static_flag),
      .rsp_final_record    (rsp_final_record),
      .fail_count          (fail_count),
      .pending_count       (pending_count)
   );

   // append one byte to the stream under construction
   task automatic put_byte(input logic [7:0] b);
      field_bytes.insert(field_bytes.size(), b);
   endtask

   // shortest coding of a value: continuing digits 191..254, last digit below 191
   task automatic put_value(input logic [63:0] v);
      logic [63:0] rest;
      logic [63:0] digit;
      int          k;
      rest = v;
      for (k = 0; k < 4; k++) begin
         if (rest < 64'(U5_LEAD_LIMIT)) begin
            put_byte(8'(rest + 64'(U5_BIAS)));
            return;
         end
         digit = 64'(U5_LEAD_LIMIT) + ((rest - 64'(U5_LEAD_LIMIT)) % DIGIT_RADIX);
         put_byte(8'(digit + 64'(U5_BIAS)));
         rest = (rest - digit) / DIGIT_RADIX;
      end
      put_byte(8'(rest + 64'(U5_BIAS)));
   endtask

   // any legal byte shape: zero bytes, zero continuation, continuing fifth byte
   task automatic put_raw_number();
      int len;
      len = $urandom_range(1, 5);
      repeat (len - 1) put_byte(8'($urandom_range(U5_CONT_LIMIT, 255)));
      if (len == 5)
         put_byte(8'($urandom));
      else if ($urandom_range(0, 7) == 0)
         put_byte(8'd0);
      else
         put_byte(8'($urandom_range(1, U5_LEAD_LIMIT)));
   endtask

   task automatic put_field();
      case ($urandom_range(0, 3))
         0, 1:    put_raw_number();
         2:       put_value(64'($urandom >> $urandom_range(0, 31)));
         default: put_value(CORNER_VALUES[$urandom_range(0, 8)]);
      endcase
   endtask

   // four fields, the flags, then one extra number per selected flag bit
   task automatic put_record(input logic [63:0] flags);
      repeat (4) put_field();
      put_value(flags);
      repeat (int'(flags[FLAG_EXTRA_A]) + int'(flags[FLAG_EXTRA_B])
              + int'(flags[FLAG_EXTRA_C]))
         put_raw_number();
   endtask

   function automatic logic [63:0] pick_flags();
      case ($urandom_range(0, 5))
         0, 1, 2: return 64'($urandom_range(0, 31));
         3, 4:    return 64'($urandom_range(0, 255));
         default: return 64'($urandom);
      endcase
   endfunction

   function automatic int next_burst();
      if ($urandom_range(0, 5) == 0)
         return int'($urandom_range(100, 300));
      return int'($urandom_range(1, 20));
   endfunction

   // result side stalls in segments of varying style
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_style <= stall_style_type'($urandom_range(0, 3));
         stall_run   <= $urandom_range(4, 60);
      end else begin
         stall_run <= stall_run - 1;
      end
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_COIN:  rsp_stall <= ($urandom_range(0, 1) == 1);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= stall_run[1];
      endcase
   end

   // watchdog on cycles with no request and no result accepted
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      // directed records: zero lead byte, largest 32-bit values, static access,
      // all three extras with zero-lead, zero-continuation and five-byte forms
      put_byte(8'd0);
      put_value(64'hFFFF_FFFF);
      put_value(64'h8000_0000);
      put_value(64'd8);
      put_value(64'h15);
      put_byte(8'd0);
      put_byte(8'd255);
      put_byte(8'd0);
      repeat (5) put_byte(8'd255);
      // lead byte boundary, access wider than 32 bits, single extra
      put_value(64'(U5_LEAD_LIMIT) - 64'd1);
      put_value(64'(U5_LEAD_LIMIT));
      put_value(64'h7FFF_FFFF);
      repeat (5) put_byte(8'd255);
      put_value(64'h1);
      put_raw_number();
      // extras from flag bits 2 and 4
      put_record(64'h14);
      record_total = 3;
      directed_len = field_bytes.size();

      while (field_bytes.size() < ITEM_TARGET) begin
         put_record(pick_flags());
         record_total++;
      end

      // header goes in front; the stream ends by count or inside a record
      record_bytes = field_bytes;
      field_bytes.delete();
      stream_end = stream_end_type'($urandom_range(0, 1));
      if (stream_end == END_BY_COUNT) begin
         head_count = $urandom_range(0, record_total);
         put_value(64'(head_count));
         put_value(64'(record_total - head_count));
      end else begin
         put_value(64'(record_total) + 64'($urandom_range(1, 5000)));
         put_raw_number();
      end
      pause_at = field_bytes.size() + directed_len;
      field_bytes = {field_bytes, record_bytes};
      if (stream_end == END_BY_COUNT) begin
         repeat ($urandom_range(0, 6)) put_byte(8'($urandom));
         eos_at = field_bytes.size();
         put_byte(8'($urandom));
      end else begin
         tail_start = field_bytes.size();
         put_record(pick_flags());
         eos_at = $urandom_range(tail_start, field_bytes.size() - 1);
         while (field_bytes.size() > eos_at + 1)
            void'(field_bytes.pop_back());
      end
      // bytes after end of stream are dropped by the block
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // send the stream in bursts
      burst_left = next_burst();
      for (i = 0; i < field_bytes.size(); i++) begin
         if (i == pause_at) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_count != 0);
         end
         req_valid         <= 1'b1;
         req_stream_byte   <= field_bytes[i];
         req_end_of_stream <= (i == eos_at);
         do @(posedge clock); while (req_stall);
         burst_left--;
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = next_burst();
         end
      end
      req_valid <= 1'b0;

      // drain and settle
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/u5frp_pkg.sv
rtl/u5frp_decode.sv
rtl/u5frp_record.sv
rtl/unsigned5_field_record_parser.sv
rtl/u5frp_checker.sv
test/field_record_checker.sv
test/testbench.sv
